/* hw/rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; clock aclk and active-low reset aresetn are assumed by name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/ies_pkg.sv */
// types, codes and reset values for the serial eeprom transaction sequencer
// no dependencies
package ies_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int MEM_ADDR_W    = 16;
    localparam int COUNT_W       = 16;
    localparam int CHUNK_W       = 9;
    localparam int MAX_RES       = 3;

    localparam logic [6:0] DEV_ADDR_RST  = 7'd80;
    localparam logic       WIDE_ADDR_RST = 1'b1;
    localparam logic [3:0] PAGE_LOG2_RST = 4'd5;
    localparam logic [7:0] WAIT_MS_RST   = 8'd5;
    localparam logic [3:0] PAGE_LOG2_MAX = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
    localparam logic [1:0] REG_WIDE_ADDR = 2'd1;
    localparam logic [1:0] REG_PAGE_LOG2 = 2'd2;
    localparam logic [1:0] REG_WAIT_MS   = 2'd3;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RESP  = 2'd2,
        CMD_DATA  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_START  = 4'd0,
        OP_SEND   = 4'd1,
        OP_RXACK  = 4'd2,
        OP_RXNACK = 4'd3,
        OP_STOP   = 4'd4,
        OP_WAIT   = 4'd5,
        OP_WANT   = 4'd6,
        OP_RDATA  = 4'd7,
        OP_OK     = 4'd8,
        OP_ERR    = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_DEV    = 4'd2,
        PH_HI     = 4'd3,
        PH_LO     = 4'd4,
        PH_RSTART = 4'd5,
        PH_DEVR   = 4'd6,
        PH_WANT   = 4'd7,
        PH_DATA   = 4'd8,
        PH_RX     = 4'd9
    } phase_t;

    typedef struct packed {
        cmd_t                    command;
        logic [MEM_ADDR_W-1:0]   mem_address;
        logic [COUNT_W-1:0]      byte_count;
        logic [7:0]              data_byte;
        logic                    acked;
        logic [7:0]              rx_byte;
    } in_t;

    typedef struct packed {
        op_t        bus_op;
        logic [7:0] op_byte;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic       wide_address;
        logic [3:0] page_size_log2;
        logic [7:0] write_wait_ms;
    } cfg_t;

    typedef struct packed {
        phase_t               phase;
        logic [COUNT_W-1:0]   bytes_remaining;
        logic [CHUNK_W-1:0]   chunk_left;
        logic                 reading;
    } seq_state_t;

endpackage

/* hw/rtl/i2c_eeprom_transaction_sequencer_top.sv */
// top level of the serial eeprom transaction sequencer
// depends on ies_pkg and ies_step
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  ies_pkg::in_t  (request, response or data byte)
//  m_       out        m_valid / m_ready  ies_pkg::out_t (bus operation, last flag)
//  cfg_     in         cfg_we             cfg_index / cfg_data register write
//
// an input transaction is worked out in the cycle it is accepted and yields 0 to 3 results,
// held in a three-entry result register, drained one result per cycle while m_ready is high
// rate: one transaction per cycle while each yields at most one result and m_ready is high;
// a group of n results holds s_ready low until the last leaves the single output port
// reset (synchronous, aresetn low) clears the sequencer state, empties the result register
// and loads the register defaults; m_ stalls only back up s_, no state is lost
module i2c_eeprom_transaction_sequencer_top #(
    parameter int ADDR_BITS = ies_pkg::ADDR_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ies_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ies_pkg::out_t m_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    ies_pkg::cfg_t        cfg_reg;
    ies_pkg::seq_state_t  st_reg;
    ies_pkg::seq_state_t  st_next;
    logic [ADDR_BITS-1:0] cur_addr_reg;
    logic [ADDR_BITS-1:0] cur_addr_next;

    // result register: entry 0 is the one shown on m_
    ies_pkg::out_t [ies_pkg::MAX_RES-1:0] res_buf_reg;
    ies_pkg::out_t [ies_pkg::MAX_RES-1:0] res_new;
    logic [1:0]                           res_cnt_reg;
    logic [1:0]                           res_new_cnt;

    logic s_accept;
    logic m_accept;

    assign m_valid  = (res_cnt_reg != 2'd0);
    assign m_data   = res_buf_reg[0];
    assign m_accept = m_valid && m_ready;
    // take a new transaction when the result register is empty or its last entry leaves now
    assign s_ready  = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_ready);
    assign s_accept = s_valid && s_ready;

    ies_step #(
        .ADDR_BITS(ADDR_BITS)
    ) u_step (
        .in_item      (s_data),
        .st           (st_reg),
        .cur_addr     (cur_addr_reg),
        .cfg          (cfg_reg),
        .st_next      (st_next),
        .cur_addr_next(cur_addr_next),
        .res          (res_new),
        .res_cnt      (res_new_cnt)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= ies_pkg::DEV_ADDR_RST;
            cfg_reg.wide_address   <= ies_pkg::WIDE_ADDR_RST;
            cfg_reg.page_size_log2 <= ies_pkg::PAGE_LOG2_RST;
            cfg_reg.write_wait_ms  <= ies_pkg::WAIT_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ies_pkg::REG_DEV_ADDR:  cfg_reg.device_address <= cfg_data[6:0];
                ies_pkg::REG_WIDE_ADDR: cfg_reg.wide_address   <= cfg_data[0];
                ies_pkg::REG_PAGE_LOG2: cfg_reg.page_size_log2 <= cfg_data[3:0];
                ies_pkg::REG_WAIT_MS:   cfg_reg.write_wait_ms  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer state advances once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase           <= ies_pkg::PH_IDLE;
            st_reg.bytes_remaining <= '0;
            st_reg.chunk_left      <= '0;
            st_reg.reading         <= 1'b0;
            cur_addr_reg           <= '0;
        end else if (s_accept) begin
            st_reg       <= st_next;
            cur_addr_reg <= cur_addr_next;
        end
    end

    // result register: load a whole group, or shift one entry out per taken result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (s_accept) begin
            res_cnt_reg <= res_new_cnt;
        end else if (m_accept) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_buf_reg <= res_new;
        end else if (m_accept) begin
            for (int i = 0; i < ies_pkg::MAX_RES - 1; i++) begin
                res_buf_reg[i] <= res_buf_reg[i + 1];
            end
        end
    end

endmodule

/* hw/rtl/ies_step.sv */
// next-state and result logic for one transaction of the sequencer
// depends on ies_pkg
module ies_step #(
    parameter int ADDR_BITS = ies_pkg::ADDR_BITS_DEF
) (
    input  ies_pkg::in_t                      in_item,
    input  ies_pkg::seq_state_t               st,
    input  logic [ADDR_BITS-1:0]              cur_addr,
    input  ies_pkg::cfg_t                     cfg,
    output ies_pkg::seq_state_t               st_next,
    output logic [ADDR_BITS-1:0]              cur_addr_next,
    output ies_pkg::out_t [ies_pkg::MAX_RES-1:0] res,
    output logic [1:0]                        res_cnt
);

    logic [ADDR_BITS-1:0]             addr_inc;
    logic [ies_pkg::MEM_ADDR_W-1:0]   cur16;
    logic [ies_pkg::MEM_ADDR_W-1:0]   bc_addr16;
    logic [ADDR_BITS-1:0]             bc_addr;
    logic [ies_pkg::COUNT_W-1:0]      bc_rem;
    logic [3:0]                       lg;
    logic [ies_pkg::CHUNK_W-1:0]      page;
    logic [ies_pkg::CHUNK_W-1:0]      page_off;
    logic [ies_pkg::CHUNK_W-1:0]      room;
    logic [ies_pkg::CHUNK_W-1:0]      chunk_len;
    logic [ies_pkg::COUNT_W-1:0]      rem_after;
    logic [ies_pkg::COUNT_W-1:0]      rem_dec;
    logic [ies_pkg::CHUNK_W-1:0]      chunk_dec;
    logic [7:0]                       dev_wr;
    logic [7:0]                       dev_rd;
    logic                             do_chunk;
    logic                             do_finish;
    ies_pkg::out_t [ies_pkg::MAX_RES-1:0] res_raw;

    function automatic ies_pkg::out_t mk(input ies_pkg::op_t op, input logic [7:0] b);
        ies_pkg::out_t r;
        r.bus_op  = op;
        r.op_byte = b;
        r.last    = 1'b0;
        return r;
    endfunction

    assign addr_inc = cur_addr + ADDR_BITS'(1);
    assign cur16    = ies_pkg::MEM_ADDR_W'(cur_addr);
    assign dev_wr   = {cfg.device_address, 1'b0};
    assign dev_rd   = {cfg.device_address, 1'b1};
    assign rem_dec  = st.bytes_remaining - ies_pkg::COUNT_W'(1);
    assign chunk_dec = st.chunk_left - ies_pkg::CHUNK_W'(1);

    // page chunk: from the request when idle, else the next address after a data byte
    assign bc_addr   = (st.phase == ies_pkg::PH_IDLE) ?
                       ADDR_BITS'(in_item.mem_address) : addr_inc;
    assign bc_rem    = (st.phase == ies_pkg::PH_IDLE) ? in_item.byte_count : st.bytes_remaining;
    assign bc_addr16 = ies_pkg::MEM_ADDR_W'(bc_addr);
    assign lg        = (cfg.page_size_log2 > ies_pkg::PAGE_LOG2_MAX) ?
                       ies_pkg::PAGE_LOG2_MAX : cfg.page_size_log2;
    assign page      = ies_pkg::CHUNK_W'(1) << lg;
    assign page_off  = {1'b0, bc_addr16[7:0]} & (page - ies_pkg::CHUNK_W'(1));
    assign room      = page - page_off;
    assign chunk_len = (ies_pkg::COUNT_W'(room) > bc_rem) ?
                       ies_pkg::CHUNK_W'(bc_rem) : room;
    assign rem_after = bc_rem - ies_pkg::COUNT_W'(chunk_len);

    always_comb begin
        st_next       = st;
        cur_addr_next = cur_addr;
        res_raw       = '0;
        res_cnt       = 2'd0;
        do_chunk      = 1'b0;
        do_finish     = 1'b0;

        unique case (in_item.command)
            ies_pkg::CMD_WRITE, ies_pkg::CMD_READ: begin
                if (st.phase == ies_pkg::PH_IDLE) begin
                    cur_addr_next      = ADDR_BITS'(in_item.mem_address);
                    st_next.bytes_remaining = in_item.byte_count;
                    st_next.chunk_left = '0;
                    st_next.reading    = (in_item.command == ies_pkg::CMD_READ);
                    res_cnt            = 2'd1;
                    if (in_item.command == ies_pkg::CMD_READ) begin
                        res_raw[0]    = mk(ies_pkg::OP_START, 8'd0);
                        st_next.phase = ies_pkg::PH_START;
                    end else if (in_item.byte_count == '0) begin
                        res_raw[0] = mk(ies_pkg::OP_OK, 8'd0);
                        do_finish  = 1'b1;
                    end else begin
                        res_raw[0] = mk(ies_pkg::OP_START, 8'd0);
                        do_chunk   = 1'b1;
                    end
                end
            end
            ies_pkg::CMD_RESP: begin
                unique case (st.phase)
                    ies_pkg::PH_START, ies_pkg::PH_RSTART: begin
                        if (!in_item.acked) begin
                            res_raw[0] = mk(ies_pkg::OP_STOP, 8'd0);
                            res_raw[1] = mk(ies_pkg::OP_ERR, 8'd0);
                            res_cnt    = 2'd2;
                            do_finish  = 1'b1;
                        end else if (st.phase == ies_pkg::PH_START) begin
                            res_raw[0]    = mk(ies_pkg::OP_SEND, dev_wr);
                            res_cnt       = 2'd1;
                            st_next.phase = ies_pkg::PH_DEV;
                        end else begin
                            res_raw[0]    = mk(ies_pkg::OP_SEND, dev_rd);
                            res_cnt       = 2'd1;
                            st_next.phase = ies_pkg::PH_DEVR;
                        end
                    end
                    ies_pkg::PH_DEV, ies_pkg::PH_HI: begin
                        res_cnt = 2'd1;
                        if (!in_item.acked) begin
                            res_raw[0] = mk(ies_pkg::OP_ERR, 8'd0);
                            do_finish  = 1'b1;
                        end else if (st.phase == ies_pkg::PH_DEV && cfg.wide_address) begin
                            res_raw[0]    = mk(ies_pkg::OP_SEND, cur16[15:8]);
                            st_next.phase = ies_pkg::PH_HI;
                        end else begin
                            res_raw[0]    = mk(ies_pkg::OP_SEND, cur16[7:0]);
                            st_next.phase = ies_pkg::PH_LO;
                        end
                    end
                    ies_pkg::PH_LO: begin
                        res_cnt = 2'd1;
                        if (!in_item.acked) begin
                            res_raw[0] = mk(ies_pkg::OP_ERR, 8'd0);
                            do_finish  = 1'b1;
                        end else if (st.reading) begin
                            res_raw[0]    = mk(ies_pkg::OP_START, 8'd0);
                            st_next.phase = ies_pkg::PH_RSTART;
                        end else begin
                            res_raw[0]    = mk(ies_pkg::OP_WANT, 8'd0);
                            st_next.phase = ies_pkg::PH_WANT;
                        end
                    end
                    ies_pkg::PH_DEVR: begin
                        if (!in_item.acked) begin
                            res_raw[0] = mk(ies_pkg::OP_ERR, 8'd0);
                            res_cnt    = 2'd1;
                            do_finish  = 1'b1;
                        end else if (st.bytes_remaining == '0) begin
                            res_raw[0] = mk(ies_pkg::OP_STOP, 8'd0);
                            res_raw[1] = mk(ies_pkg::OP_OK, 8'd0);
                            res_cnt    = 2'd2;
                            do_finish  = 1'b1;
                        end else begin
                            res_raw[0] = mk((st.bytes_remaining == ies_pkg::COUNT_W'(1)) ?
                                            ies_pkg::OP_RXNACK : ies_pkg::OP_RXACK, 8'd0);
                            res_cnt       = 2'd1;
                            st_next.phase = ies_pkg::PH_RX;
                        end
                    end
                    ies_pkg::PH_DATA: begin
                        if (!in_item.acked) begin
                            res_raw[0] = mk(ies_pkg::OP_ERR, 8'd0);
                            res_cnt    = 2'd1;
                            do_finish  = 1'b1;
                        end else begin
                            cur_addr_next      = addr_inc;
                            st_next.chunk_left = chunk_dec;
                            if (chunk_dec != '0) begin
                                res_raw[0]    = mk(ies_pkg::OP_WANT, 8'd0);
                                res_cnt       = 2'd1;
                                st_next.phase = ies_pkg::PH_WANT;
                            end else begin
                                // page done: stop, programming wait, then next page or done
                                res_raw[0] = mk(ies_pkg::OP_STOP, 8'd0);
                                res_raw[1] = mk(ies_pkg::OP_WAIT, cfg.write_wait_ms);
                                res_cnt    = 2'd3;
                                if (st.bytes_remaining != '0) begin
                                    res_raw[2] = mk(ies_pkg::OP_START, 8'd0);
                                    do_chunk   = 1'b1;
                                end else begin
                                    res_raw[2] = mk(ies_pkg::OP_OK, 8'd0);
                                    do_finish  = 1'b1;
                                end
                            end
                        end
                    end
                    ies_pkg::PH_RX: begin
                        res_raw[0] = mk(ies_pkg::OP_RDATA, in_item.rx_byte);
                        st_next.bytes_remaining = rem_dec;
                        if (rem_dec != '0) begin
                            res_raw[1] = mk((rem_dec == ies_pkg::COUNT_W'(1)) ?
                                            ies_pkg::OP_RXNACK : ies_pkg::OP_RXACK, 8'd0);
                            res_cnt    = 2'd2;
                        end else begin
                            res_raw[1] = mk(ies_pkg::OP_STOP, 8'd0);
                            res_raw[2] = mk(ies_pkg::OP_OK, 8'd0);
                            res_cnt    = 2'd3;
                            do_finish  = 1'b1;
                        end
                    end
                    default: begin
                        // idle or waiting for host data: response ignored
                    end
                endcase
            end
            ies_pkg::CMD_DATA: begin
                if (st.phase == ies_pkg::PH_WANT) begin
                    res_raw[0]    = mk(ies_pkg::OP_SEND, in_item.data_byte);
                    res_cnt       = 2'd1;
                    st_next.phase = ies_pkg::PH_DATA;
                end
            end
            default: begin
            end
        endcase

        if (do_chunk) begin
            st_next.chunk_left      = chunk_len;
            st_next.bytes_remaining = rem_after;
            st_next.phase           = ies_pkg::PH_START;
        end
        if (do_finish) begin
            st_next.phase           = ies_pkg::PH_IDLE;
            st_next.reading         = 1'b0;
            st_next.bytes_remaining = '0;
            st_next.chunk_left      = '0;
        end
    end

    // flag the final result of the group
    always_comb begin
        res = res_raw;
        for (int i = 0; i < ies_pkg::MAX_RES; i++) begin
            res[i].last = (2'(i + 1) == res_cnt);
        end
    end

endmodule

/* hw/rtl/ies_checker.sv */
// port-level checks of the transaction sequencer, bound to the top level
// depends on ies_pkg, assert_macros.svh and i2c_eeprom_transaction_sequencer_top
`include "assert_macros.svh"

module ies_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input ies_pkg::out_t m_data
);

    logic m_stall;
    logic m_take;
    logic m_done;

    assign m_stall = m_valid && !m_ready;
    assign m_take  = m_valid && m_ready;
    assign m_done  = m_valid && (m_data.bus_op == ies_pkg::OP_OK ||
                                 m_data.bus_op == ies_pkg::OP_ERR);

    // a stalled result holds
    `ASSERT_CLK(a_m_hold, m_stall |=> (m_valid && $stable(m_data)), "stalled result changed")

    // reset empties the result register
    `ASSERT_CLK_ALWAYS(a_rst_empty, !aresetn |=> !m_valid, "result pending after reset")

    // a group continues until its last result
    `ASSERT_CLK(a_group_cont, (m_take && !m_data.last) |=> m_valid, "result group cut short")

    // input is held back only behind pending results
    `ASSERT_CLK(a_ready_blk, !s_ready |-> m_valid, "input stalled with no pending result")

    // completion codes end their group
    `ASSERT_CLK(a_done_last, m_done |-> m_data.last, "completion not marked last")

endmodule

bind i2c_eeprom_transaction_sequencer_top ies_checker u_ies_checker (.*);
